/* rtl/core/lls_pkg.sv */
// Shared types, codes and constants for the link lease supervisor.
// No dependencies; every other file of the block imports this package.
package lls_pkg;

    // Event codes on the op field
    localparam logic [3:0] OP_POLL       = 4'd0;
    localparam logic [3:0] OP_CONNECT    = 4'd1;
    localparam logic [3:0] OP_DISCONNECT = 4'd2;
    localparam logic [3:0] OP_MTU        = 4'd3;
    localparam logic [3:0] OP_SUBSCRIBE  = 4'd4;
    localparam logic [3:0] OP_ENC_CHANGE = 4'd5;
    localparam logic [3:0] OP_TERM_FAIL  = 4'd6;
    localparam logic [3:0] OP_PACKET     = 4'd7;
    localparam logic [3:0] OP_SYNC       = 4'd8;
    localparam logic [3:0] OP_HOST_RESET = 4'd9;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAL_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_GRACE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_RETRY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENC_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_HANDLE    = 3'd5;

    localparam logic [31:0] TERM_GRACE_RST = 32'd5000;
    localparam logic [31:0] TERM_RETRY_RST = 32'd1000;

    localparam logic [7:0]  MIN_PAYLOAD = 8'd20;
    localparam logic [7:0]  MAX_PAYLOAD = 8'd255;
    localparam logic [15:0] MTU_HEADER  = 16'd3;
    localparam logic [15:0] NO_HANDLE   = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_DOWN   = 2'd0,
        PH_QUAL   = 2'd1,
        PH_ACTIVE = 2'd2,
        PH_TERM   = 2'd3
    } phase_t;

    // Classified event, as carried out by the back end
    typedef enum logic [3:0] {
        EV_NONE,
        EV_POLL,
        EV_CONNECT,
        EV_DISCONNECT,
        EV_MTU,
        EV_SUBSCRIBE,
        EV_ENC,
        EV_PACKET,
        EV_SYNC,
        EV_HOST_RESET
    } ev_t;

    typedef struct packed {
        logic [31:0] qual_timeout;
        logic [31:0] idle_timeout;
        logic [31:0] term_grace;
        logic [31:0] term_retry;
        logic        enc_mode;
        logic [15:0] tx_handle;
    } lls_cfg_t;

    typedef struct packed {
        ev_t         ev;
        logic [31:0] now;
        logic [15:0] hnd;
        logic [7:0]  mtu;
        logic        attr_match;
        logic        notify_on;
        logic        gone;
        logic        sec_term;
    } lls_cmd_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] handle;
        logic [7:0]  mtu;
        logic        notify_en;
        logic        packet_seen;
        logic        reset_req;
        logic        host_ready;
        logic [31:0] qual_start;
        logic [31:0] last_pkt;
        logic [31:0] term_start;
        logic [31:0] last_try;
        logic [31:0] conn_count;
    } lls_state_t;

    typedef struct packed {
        phase_t      phase;
        logic        connected;
        logic        subscribed;
        logic [7:0]  mtu;
        logic [31:0] generation;
        logic [15:0] active_handle;
        logic        send_terminate;
        logic        host_reset_req;
        logic        advertise_req;
        logic        parser_reset;
        logic        poll_needed;
    } lls_res_t;

    function automatic lls_state_t lls_clear_link(input lls_state_t x);
        lls_state_t y;
        y             = x;
        y.phase       = PH_DOWN;
        y.handle      = NO_HANDLE;
        y.mtu         = MIN_PAYLOAD;
        y.notify_en   = 1'b0;
        y.packet_seen = 1'b0;
        y.reset_req   = 1'b0;
        y.qual_start  = '0;
        y.last_pkt    = '0;
        y.term_start  = '0;
        y.last_try    = '0;
        return y;
    endfunction

endpackage

/* rtl/core/lls_front.sv */
// Front end: classifies one incoming event into a command for the back end.
// Depends on lls_pkg (codes, command and configuration types).
module lls_front (
    input  logic [3:0]        op,
    input  logic [31:0]       now,
    input  logic [15:0]       link_handle,
    input  logic [7:0]        event_status,
    input  logic [15:0]       offered_mtu,
    input  logic [15:0]       attr_id,
    input  logic              notify_on,
    input  logic              peer_gone,
    input  logic              security_failed,
    input  lls_pkg::lls_cfg_t cfg,
    output lls_pkg::lls_cmd_t cmd
);
    import lls_pkg::*;

    logic        status_ok;
    logic [15:0] mtu_sub;
    logic [7:0]  mtu_clamped;

    assign status_ok = (event_status == 8'd0);
    assign mtu_sub   = offered_mtu - MTU_HEADER;

    // Drop the header bytes, then saturate into the payload range
    always_comb
    begin
        priority if (offered_mtu <= MTU_HEADER)
            mtu_clamped = MIN_PAYLOAD;
        else if (mtu_sub > {8'd0, MAX_PAYLOAD})
            mtu_clamped = MAX_PAYLOAD;
        else if (mtu_sub < {8'd0, MIN_PAYLOAD})
            mtu_clamped = MIN_PAYLOAD;
        else
            mtu_clamped = mtu_sub[7:0];
    end

    always_comb
    begin
        cmd            = '0;
        cmd.now        = now;
        cmd.hnd        = link_handle;
        cmd.mtu        = mtu_clamped;
        cmd.attr_match = (attr_id == cfg.tx_handle);
        cmd.notify_on  = notify_on;
        cmd.gone       = peer_gone;
        cmd.sec_term   = cfg.enc_mode & security_failed;
        unique case (op)
            OP_POLL:       cmd.ev = EV_POLL;
            OP_CONNECT:    cmd.ev = status_ok ? EV_CONNECT : EV_NONE;
            OP_DISCONNECT: cmd.ev = EV_DISCONNECT;
            OP_MTU:        cmd.ev = EV_MTU;
            OP_SUBSCRIBE:  cmd.ev = EV_SUBSCRIBE;
            OP_ENC_CHANGE: cmd.ev = status_ok ? EV_ENC : EV_NONE;
            OP_TERM_FAIL:  cmd.ev = EV_NONE;
            OP_PACKET:     cmd.ev = EV_PACKET;
            OP_SYNC:       cmd.ev = EV_SYNC;
            OP_HOST_RESET: cmd.ev = EV_HOST_RESET;
            default:       cmd.ev = EV_NONE;
        endcase
    end

endmodule

/* rtl/core/lls_queue.sv */
// Two-entry command queue between the front and back ends.
// Depends on lls_pkg (command type).
module lls_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lls_pkg::lls_cmd_t push_cmd,
    input  logic              pop,
    output lls_pkg::lls_cmd_t head_cmd,
    output logic              full,
    output logic              empty
);
    import lls_pkg::*;

    lls_cmd_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* rtl/core/lls_back.sv */
// Back end: link state, timeout checks and the registered result stage.
// Depends on lls_pkg (state, command, result and configuration types).
module lls_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lls_pkg::lls_cfg_t cfg,
    input  lls_pkg::lls_cmd_t cmd,
    input  logic              cmd_ready,
    output logic              cmd_pop,
    output lls_pkg::lls_res_t res,
    output logic              res_valid,
    input  logic              res_stall
);
    import lls_pkg::*;

    lls_state_t st_reg, st_next;
    lls_res_t   res_reg, res_next;
    logic       res_valid_reg, res_valid_next;
    logic       p_term, p_host_reset, p_parser;
    logic       exp_qual, exp_idle, exp_grace, exp_retry;
    logic       hnd_match;

    assign cmd_pop   = cmd_ready & (~res_valid_reg | ~res_stall);
    assign hnd_match = (cmd.hnd == st_reg.handle);

    // Elapsed time wraps modulo 2^32; a limit of zero disables the check
    assign exp_qual  = (cfg.qual_timeout != '0) &&
                       ((cmd.now - st_reg.qual_start) >= cfg.qual_timeout);
    assign exp_idle  = (cfg.idle_timeout != '0) &&
                       ((cmd.now - st_reg.last_pkt) >= cfg.idle_timeout);
    assign exp_grace = (cfg.term_grace != '0) &&
                       ((cmd.now - st_reg.term_start) >= cfg.term_grace);
    assign exp_retry = (cfg.term_retry != '0) &&
                       ((cmd.now - st_reg.last_try) >= cfg.term_retry);

    // Next link state and request pulses
    always_comb
    begin
        st_next      = st_reg;
        p_term       = 1'b0;
        p_host_reset = 1'b0;
        p_parser     = 1'b0;
        unique case (cmd.ev)
            EV_POLL:
            begin
                if (st_reg.host_ready && st_reg.phase != PH_DOWN)
                begin
                    priority if ((st_reg.phase == PH_QUAL && exp_qual) ||
                                 (st_reg.phase == PH_ACTIVE && exp_idle))
                    begin
                        p_parser = 1'b1;
                        if (cmd.gone)
                            st_next = lls_clear_link(st_reg);
                        else
                        begin
                            st_next.phase      = PH_TERM;
                            st_next.term_start = cmd.now;
                            st_next.last_try   = cmd.now;
                            p_term             = 1'b1;
                        end
                    end
                    else if (st_reg.phase == PH_TERM)
                    begin
                        priority if (exp_grace)
                        begin
                            priority if (cmd.gone)
                            begin
                                st_next  = lls_clear_link(st_reg);
                                p_parser = 1'b1;
                            end
                            else if (!st_reg.reset_req)
                            begin
                                st_next.reset_req = 1'b1;
                                p_host_reset      = 1'b1;
                            end
                            else
                                st_next = st_reg;
                        end
                        else if (exp_retry)
                        begin
                            if (cmd.gone)
                            begin
                                st_next  = lls_clear_link(st_reg);
                                p_parser = 1'b1;
                            end
                            else
                            begin
                                st_next.last_try = cmd.now;
                                p_term           = 1'b1;
                            end
                        end
                        else
                            st_next = st_reg;
                    end
                    else
                        st_next = st_reg;
                end
            end
            EV_CONNECT:
            begin
                st_next.handle      = cmd.hnd;
                st_next.mtu         = MIN_PAYLOAD;
                st_next.notify_en   = 1'b0;
                st_next.packet_seen = 1'b0;
                st_next.reset_req   = 1'b0;
                st_next.qual_start  = cmd.now;
                st_next.last_pkt    = '0;
                st_next.conn_count  = st_reg.conn_count + 32'd1;
                st_next.phase       = PH_QUAL;
                p_parser            = 1'b1;
                // Security refused: start termination straight away, or clear the link if the peer is gone
                if (cmd.sec_term)
                begin
                    if (cmd.gone)
                        st_next = lls_clear_link(st_next);
                    else
                    begin
                        st_next.phase      = PH_TERM;
                        st_next.term_start = cmd.now;
                        st_next.last_try   = cmd.now;
                        p_term             = 1'b1;
                    end
                end
            end
            EV_DISCONNECT:
            begin
                if (st_reg.handle == NO_HANDLE || hnd_match)
                begin
                    st_next  = lls_clear_link(st_reg);
                    p_parser = 1'b1;
                end
            end
            EV_MTU:
            begin
                if (hnd_match && st_reg.phase != PH_DOWN)
                    st_next.mtu = cmd.mtu;
            end
            EV_SUBSCRIBE:
            begin
                if (hnd_match && cmd.attr_match &&
                    (st_reg.phase == PH_QUAL || st_reg.phase == PH_ACTIVE))
                begin
                    st_next.notify_en = cmd.notify_on;
                    if (!cmd.notify_on && st_reg.phase == PH_ACTIVE)
                    begin
                        st_next.phase       = PH_QUAL;
                        st_next.packet_seen = 1'b0;
                        st_next.qual_start  = cmd.now;
                    end
                    if (st_next.phase == PH_QUAL && st_next.notify_en &&
                        st_next.packet_seen)
                        st_next.phase = PH_ACTIVE;
                end
            end
            EV_ENC:
            begin
                if (hnd_match && st_reg.phase == PH_QUAL)
                    st_next.qual_start = cmd.now;
            end
            EV_PACKET:
            begin
                if (st_reg.phase == PH_QUAL || st_reg.phase == PH_ACTIVE)
                begin
                    st_next.last_pkt    = cmd.now;
                    st_next.packet_seen = 1'b1;
                    if (st_reg.phase == PH_QUAL && st_reg.notify_en)
                        st_next.phase = PH_ACTIVE;
                end
            end
            EV_SYNC:
            begin
                st_next.host_ready = 1'b1;
                st_next.reset_req  = 1'b0;
            end
            EV_HOST_RESET:
            begin
                st_next            = lls_clear_link(st_reg);
                st_next.host_ready = 1'b0;
                p_parser           = 1'b1;
            end
            EV_NONE:
            begin
                st_next = st_reg;
            end
            default:
            begin
                st_next = st_reg;
            end
        endcase
    end

    // Result snapshot taken from the state after the event
    always_comb
    begin
        res_next.phase          = st_next.phase;
        res_next.connected      = (st_next.phase == PH_QUAL) ||
                                  (st_next.phase == PH_ACTIVE);
        res_next.subscribed     = res_next.connected & st_next.notify_en;
        res_next.mtu            = st_next.mtu;
        res_next.generation     = st_next.conn_count;
        res_next.active_handle  = st_next.handle;
        res_next.send_terminate = p_term;
        res_next.host_reset_req = p_host_reset;
        res_next.advertise_req  = st_next.host_ready & (st_next.phase == PH_DOWN);
        res_next.parser_reset   = p_parser;
        res_next.poll_needed    = (st_next.phase == PH_TERM) ||
                                  (st_next.phase == PH_QUAL &&
                                   cfg.qual_timeout != '0) ||
                                  (st_next.phase == PH_ACTIVE &&
                                   cfg.idle_timeout != '0);
    end

    always_comb
    begin
        priority if (cmd_pop)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase       <= PH_DOWN;
            st_reg.handle      <= NO_HANDLE;
            st_reg.mtu         <= MIN_PAYLOAD;
            st_reg.notify_en   <= 1'b0;
            st_reg.packet_seen <= 1'b0;
            st_reg.reset_req   <= 1'b0;
            st_reg.host_ready  <= 1'b0;
            st_reg.qual_start  <= '0;
            st_reg.last_pkt    <= '0;
            st_reg.term_start  <= '0;
            st_reg.last_try    <= '0;
            st_reg.conn_count  <= '0;
            res_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
                st_reg <= st_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            res_reg <= res_next;
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

/* rtl/core/link_lease_supervisor.sv */
// Top level of the link lease supervisor: configuration registers and the
// front end, command queue and back end. Depends on lls_pkg and lls_front,
// lls_queue, lls_back.
//
// Usage:
//   Event channel (evt_valid / evt_stall): one timestamped link event per
//   transfer, taken at an edge with evt_valid high and evt_stall low.
//   Result channel (res_valid / res_stall): exactly one result per event,
//   a snapshot of the link after the event plus single-result request pulses
//   (send_terminate, host_reset_req, parser_reset).
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//   cfg_ready is always high; indexes past the last register are dropped.
//   Write configuration only while no event is in flight.
// Flow: a transferred event is written into the queue, carried out when the
// back end pops it, and its result is then offered from the output register;
// one event per cycle is sustained while res_stall stays low.
// Reset: all link state returns to down with no handle, MTU 20 and a
// generation of zero; the configuration takes its default values.
// Stall: a stalled result holds in the output register; the two-entry queue
// keeps taking events until it fills, then evt_stall rises.
module link_lease_supervisor (
    input  logic        clk,
    input  logic        rst_n,
    // event channel
    input  logic        evt_valid,
    output logic        evt_stall,
    input  logic [3:0]  op,
    input  logic [31:0] now,
    input  logic [15:0] link_handle,
    input  logic [7:0]  event_status,
    input  logic [15:0] offered_mtu,
    input  logic [15:0] attr_id,
    input  logic        notify_on,
    input  logic        peer_gone,
    input  logic        security_failed,
    // result channel
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  phase,
    output logic        connected,
    output logic        subscribed,
    output logic [7:0]  mtu,
    output logic [31:0] generation,
    output logic [15:0] active_handle,
    output logic        send_terminate,
    output logic        host_reset_req,
    output logic        advertise_req,
    output logic        parser_reset,
    output logic        poll_needed,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import lls_pkg::*;

    lls_cfg_t cfg_reg;
    lls_cmd_t front_cmd;
    lls_cmd_t head_cmd;
    lls_res_t res;
    logic     q_full, q_empty, q_pop;
    logic     cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    // Configuration registers: written by index, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.qual_timeout <= '0;
            cfg_reg.idle_timeout <= '0;
            cfg_reg.term_grace   <= TERM_GRACE_RST;
            cfg_reg.term_retry   <= TERM_RETRY_RST;
            cfg_reg.enc_mode     <= 1'b0;
            cfg_reg.tx_handle    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_QUAL_TIMEOUT: cfg_reg.qual_timeout <= cfg_data;
                CFG_IDLE_TIMEOUT: cfg_reg.idle_timeout <= cfg_data;
                CFG_TERM_GRACE:   cfg_reg.term_grace   <= cfg_data;
                CFG_TERM_RETRY:   cfg_reg.term_retry   <= cfg_data;
                CFG_ENC_MODE:     cfg_reg.enc_mode     <= cfg_data[0];
                CFG_TX_HANDLE:    cfg_reg.tx_handle    <= cfg_data[15:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Classify the event on the way in
    lls_front u_front (
        .op              (op),
        .now             (now),
        .link_handle     (link_handle),
        .event_status    (event_status),
        .offered_mtu     (offered_mtu),
        .attr_id         (attr_id),
        .notify_on       (notify_on),
        .peer_gone       (peer_gone),
        .security_failed (security_failed),
        .cfg             (cfg_reg),
        .cmd             (front_cmd)
    );

    // Hold classified commands while the back end or the receiver stalls
    lls_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (evt_valid),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    assign evt_stall = q_full;

    // Carry out the command and register the result
    lls_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (head_cmd),
        .cmd_ready (~q_empty),
        .cmd_pop   (q_pop),
        .res       (res),
        .res_valid (res_valid),
        .res_stall (res_stall)
    );

    assign phase          = res.phase;
    assign connected      = res.connected;
    assign subscribed     = res.subscribed;
    assign mtu            = res.mtu;
    assign generation     = res.generation;
    assign active_handle  = res.active_handle;
    assign send_terminate = res.send_terminate;
    assign host_reset_req = res.host_reset_req;
    assign advertise_req  = res.advertise_req;
    assign parser_reset   = res.parser_reset;
    assign poll_needed    = res.poll_needed;

endmodule
